// File: hw/rtl/ray_square_intersect_macros.svh
// Assertion macros shared by the ray/square intersection checker
`ifndef RAY_SQUARE_INTERSECT_MACROS_SVH
`define RAY_SQUARE_INTERSECT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray_square_intersect: check failed");

// next-cycle implication, disabled during reset
`define RSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ray_square_intersect: check failed");

`endif

// File: hw/rtl/rsi_pkg.sv
// Shared widths, constants and register codes for the ray/square intersection block
package rsi_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;

    // field widths
    localparam int CRD_W      = 32;
    localparam int NRM_W      = 18;
    localparam int LEN_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // plane parameter datapath
    localparam int DN_W  = CRD_W + NRM_W;
    localparam int CN_W  = CRD_W + 1 + NRM_W;
    localparam int DEN_W = DN_W + 2;
    localparam int NUM_W = CN_W + 2;
    localparam int RW    = DEN_W;
    localparam int QW    = 32;

    // hit point and in-plane axes
    localparam int PRD_W = 2 * CRD_W;
    localparam int VW    = PRD_W - FRAC_BITS + 2;
    localparam int SW    = NRM_W + 1;
    localparam int UR_W  = NRM_W + SW + 1;
    localparam int WW    = (UR_W - FRAC_BITS > SW) ? UR_W - FRAC_BITS : SW;
    localparam int WWS   = 2 * WW + 1;
    localparam int PDW   = VW + WW;
    localparam int DW    = PDW + 2;

    // size test
    localparam int HALF_W = 31;
    localparam int MAG_W  = 2 * HALF_W;
    localparam int PP_W   = 64;
    localparam int CMP_W  = 128;

    localparam logic [QW-1:0] T_MIN = QW'(((1 << FRAC_BITS) + 999) / 1000);
    localparam logic signed [NRM_W-1:0] NRM_ONE  = NRM_W'(1 << FRAC_BITS);
    localparam logic signed [NRM_W-1:0] NRM_MONE = -NRM_ONE;
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1 << FRAC_BITS);

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_NORMAL_X,
        REG_NORMAL_Y,
        REG_NORMAL_Z,
        REG_SIDE
    } cfg_reg_t;

endpackage

// File: hw/rtl/ray_square_intersect.sv
// Pipelined ray versus square intersection test in signed fixed point
//
// One ray is accepted per clock while in_stall is low, that is while the skid
// register is empty. Each ray runs through a fixed pipeline of 42 register
// stages followed by an output register; the depth is set by the plane
// parameter divider, which resolves one quotient bit per stage over 32
// stages. A stalled output fills a one-item skid register, and the input
// stalls only while that skid register is full. Configuration registers
// feed a four-stage derived-constant pipeline (side axes, their squared
// lengths, squared side); write them only while no ray is in flight and
// allow a few cycles before the next ray. No clearing pass after reset.
module ray_square_intersect (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [rsi_pkg::CRD_W-1:0]      origin_x,
    input  logic signed [rsi_pkg::CRD_W-1:0]      origin_y,
    input  logic signed [rsi_pkg::CRD_W-1:0]      origin_z,
    input  logic signed [rsi_pkg::CRD_W-1:0]      dir_x,
    input  logic signed [rsi_pkg::CRD_W-1:0]      dir_y,
    input  logic signed [rsi_pkg::CRD_W-1:0]      dir_z,
    input  logic        [rsi_pkg::LEN_W-1:0]      max_distance,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  hit,
    output logic        [rsi_pkg::LEN_W-1:0]      distance,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [rsi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rsi_pkg::*;

    // configuration registers
    logic signed [CRD_W-1:0] center_reg [3];
    logic signed [NRM_W-1:0] normal_reg [3];
    logic        [LEN_W-1:0] side_reg;

    // derived constants
    logic signed [SW-1:0]    s_c [3];
    logic signed [UR_W-1:0]  cr_c [3];
    logic signed [UR_W-1:0]  crs_c [3];
    logic                    ny_unit;
    logic signed [WW-1:0]    s_reg [3];
    logic signed [WW-1:0]    u_reg [3];
    logic                    sdeg_reg;
    logic signed [WWS-1:0]   ww_next [2];
    logic        [WWS-1:0]   ww_reg [2];
    logic        [MAG_W-1:0] l2_reg;
    logic        [PP_W-1:0]  cpp_next [2][4];
    logic        [PP_W-1:0]  cpp_reg [2][4];
    logic        [CMP_W-1:0] rhs_next [2];
    logic        [CMP_W-1:0] rhs_reg [2];

    // flow control
    logic en;
    logic out_free;

    // input views
    logic signed [CRD_W-1:0] in_o [3];
    logic signed [CRD_W-1:0] in_d [3];

    // stage 1: products with the normal
    logic                    s1_valid_reg;
    logic signed [CRD_W-1:0] s1_o_reg [3];
    logic signed [CRD_W-1:0] s1_d_reg [3];
    logic        [LEN_W-1:0] s1_lim_reg;
    logic signed [CRD_W:0]   diff_c [3];
    logic signed [DN_W-1:0]  s1_pdn_next [3];
    logic signed [DN_W-1:0]  s1_pdn_reg [3];
    logic signed [CN_W-1:0]  s1_pcn_next [3];
    logic signed [CN_W-1:0]  s1_pcn_reg [3];

    // stage 2: dot products
    logic                     s2_valid_reg;
    logic signed [CRD_W-1:0]  s2_o_reg [3];
    logic signed [CRD_W-1:0]  s2_d_reg [3];
    logic        [LEN_W-1:0]  s2_lim_reg;
    logic signed [DEN_W-1:0]  s2_den_next;
    logic signed [DEN_W-1:0]  s2_den_reg;
    logic signed [NUM_W-1:0]  s2_num_next;
    logic signed [NUM_W-1:0]  s2_num_reg;

    // divider stages
    logic                    num_neg;
    logic                    den_neg;
    logic        [NUM_W-1:0] an_c;
    logic        [DEN_W-1:0] ad_c;
    logic        [RW-1:0]    rem0_c;
    logic                    dv_valid_next [QW+1];
    logic                    dv_valid_reg [QW+1];
    logic                    dv_miss_next [QW+1];
    logic                    dv_miss_reg [QW+1];
    logic        [RW-1:0]    dv_rem_next [QW+1];
    logic        [RW-1:0]    dv_rem_reg [QW+1];
    logic        [QW-1:0]    dv_nlo_next [QW+1];
    logic        [QW-1:0]    dv_nlo_reg [QW+1];
    logic        [QW-1:0]    dv_q_next [QW+1];
    logic        [QW-1:0]    dv_q_reg [QW+1];
    logic        [DEN_W-1:0] dv_dmag_next [QW+1];
    logic        [DEN_W-1:0] dv_dmag_reg [QW+1];
    logic        [LEN_W-1:0] dv_lim_next [QW+1];
    logic        [LEN_W-1:0] dv_lim_reg [QW+1];
    logic signed [CRD_W-1:0] dv_o_next [QW+1][3];
    logic signed [CRD_W-1:0] dv_o_reg [QW+1][3];
    logic signed [CRD_W-1:0] dv_d_next [QW+1][3];
    logic signed [CRD_W-1:0] dv_d_reg [QW+1][3];
    logic        [RW-1:0]    trial_c [QW];
    logic                    ge_c [QW];

    // stage M: range check and d*t
    logic                    sm_valid_reg;
    logic                    sm_miss_next;
    logic                    sm_miss_reg;
    logic        [LEN_W-1:0] sm_t_reg;
    logic signed [CRD_W-1:0] sm_o_reg [3];
    logic signed [PRD_W-1:0] sm_prod_next [3];
    logic signed [PRD_W-1:0] sm_prod_reg [3];

    // stage V: offset from center
    logic                    sv_valid_reg;
    logic                    sv_miss_reg;
    logic        [LEN_W-1:0] sv_t_reg;
    logic signed [PRD_W-1:0] sv_wide_c [3];
    logic signed [VW-1:0]    sv_v_reg [3];

    // size test stages
    logic                    sd1_valid_reg;
    logic                    sd1_miss_reg;
    logic        [LEN_W-1:0] sd1_t_reg;
    logic signed [PDW-1:0]   sd1_ps_reg [3];
    logic signed [PDW-1:0]   sd1_pu_reg [3];
    logic                    sd2_valid_reg;
    logic                    sd2_miss_reg;
    logic        [LEN_W-1:0] sd2_t_reg;
    logic signed [DW-1:0]    sd2_dot_next [2];
    logic signed [DW-1:0]    sd2_dot_reg [2];
    logic                    sd3_valid_reg;
    logic                    sd3_miss_reg;
    logic        [LEN_W-1:0] sd3_t_reg;
    logic        [DW-1:0]    mag_c [2];
    logic        [MAG_W-1:0] sd3_mag_reg [2];
    logic                    sd3_big_reg [2];
    logic                    sd4_valid_reg;
    logic                    sd4_miss_reg;
    logic        [LEN_W-1:0] sd4_t_reg;
    logic                    sd4_big_reg [2];
    logic        [MAG_W-1:0] sd4_pp_next [2][3];
    logic        [MAG_W-1:0] sd4_pp_reg [2][3];
    logic        [CMP_W-1:0] lhs_c [2];
    logic                    ok_c [2];
    logic                    pv_hit_next;

    // last pipeline stage, skid and output registers
    logic                    pv_valid_reg;
    logic                    pv_hit_reg;
    logic        [LEN_W-1:0] pv_dist_reg;
    logic                    skid_valid_next;
    logic                    skid_valid_reg;
    logic                    skid_hit_next;
    logic                    skid_hit_reg;
    logic        [LEN_W-1:0] skid_dist_next;
    logic        [LEN_W-1:0] skid_dist_reg;
    logic                    out_valid_next;
    logic                    out_valid_reg;
    logic                    out_hit_next;
    logic                    out_hit_reg;
    logic        [LEN_W-1:0] out_dist_next;
    logic        [LEN_W-1:0] out_dist_reg;

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_o[0] = origin_x;
    assign in_o[1] = origin_y;
    assign in_o[2] = origin_z;
    assign in_d[0] = dir_x;
    assign in_d[1] = dir_y;
    assign in_d[2] = dir_z;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                center_reg[i] <= '0;
            end
            normal_reg[0] <= '0;
            normal_reg[1] <= NRM_ONE;
            normal_reg[2] <= '0;
            side_reg      <= LEN_ONE;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X: center_reg[0] <= cfg_data[CRD_W-1:0];
                REG_CENTER_Y: center_reg[1] <= cfg_data[CRD_W-1:0];
                REG_CENTER_Z: center_reg[2] <= cfg_data[CRD_W-1:0];
                REG_NORMAL_X: normal_reg[0] <= cfg_data[NRM_W-1:0];
                REG_NORMAL_Y: normal_reg[1] <= cfg_data[NRM_W-1:0];
                REG_NORMAL_Z: normal_reg[2] <= cfg_data[NRM_W-1:0];
                REG_SIDE:     side_reg      <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // side axis s and second axis u = floor((n x s) / one)
    always_comb
    begin
        ny_unit = (normal_reg[1] == NRM_ONE) || (normal_reg[1] == NRM_MONE);
        if (ny_unit)
        begin
            s_c[0] = '0;
            s_c[1] = {normal_reg[2][NRM_W-1], normal_reg[2]};
            s_c[2] = -{normal_reg[1][NRM_W-1], normal_reg[1]};
        end
        else
        begin
            s_c[0] = -{normal_reg[2][NRM_W-1], normal_reg[2]};
            s_c[1] = '0;
            s_c[2] = {normal_reg[0][NRM_W-1], normal_reg[0]};
        end
        cr_c[0] = UR_W'(normal_reg[1]) * UR_W'(s_c[2]) - UR_W'(normal_reg[2]) * UR_W'(s_c[1]);
        cr_c[1] = UR_W'(normal_reg[2]) * UR_W'(s_c[0]) - UR_W'(normal_reg[0]) * UR_W'(s_c[2]);
        cr_c[2] = UR_W'(normal_reg[0]) * UR_W'(s_c[1]) - UR_W'(normal_reg[1]) * UR_W'(s_c[0]);
        for (int i = 0; i < 3; i++)
        begin
            crs_c[i] = cr_c[i] >>> FRAC_BITS;
        end
    end

    // squared axis lengths and partial products of l^2 * |w|^2
    always_comb
    begin
        ww_next[0] = WWS'(s_reg[0]) * WWS'(s_reg[0]) + WWS'(s_reg[1]) * WWS'(s_reg[1])
                   + WWS'(s_reg[2]) * WWS'(s_reg[2]);
        ww_next[1] = WWS'(u_reg[0]) * WWS'(u_reg[0]) + WWS'(u_reg[1]) * WWS'(u_reg[1])
                   + WWS'(u_reg[2]) * WWS'(u_reg[2]);
        for (int a = 0; a < 2; a++)
        begin
            cpp_next[a][0] = PP_W'(l2_reg[HALF_W-1:0]) * PP_W'(ww_reg[a][HALF_W-1:0]);
            cpp_next[a][1] = PP_W'(l2_reg[HALF_W-1:0]) * PP_W'(ww_reg[a][WWS-1:HALF_W]);
            cpp_next[a][2] = PP_W'(l2_reg[MAG_W-1:HALF_W]) * PP_W'(ww_reg[a][HALF_W-1:0]);
            cpp_next[a][3] = PP_W'(l2_reg[MAG_W-1:HALF_W]) * PP_W'(ww_reg[a][WWS-1:HALF_W]);
            rhs_next[a] = CMP_W'(cpp_reg[a][0])
                        + (CMP_W'(cpp_reg[a][1]) << HALF_W)
                        + (CMP_W'(cpp_reg[a][2]) << HALF_W)
                        + (CMP_W'(cpp_reg[a][3]) << MAG_W);
        end
    end

    // derived constant registers, refreshed every cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_reg[i] <= WW'(s_c[i]);
            u_reg[i] <= crs_c[i][WW-1:0];
        end
        sdeg_reg <= (s_c[0] == '0) && (s_c[1] == '0) && (s_c[2] == '0);
        for (int a = 0; a < 2; a++)
        begin
            ww_reg[a]  <= ww_next[a];
            cpp_reg[a] <= cpp_next[a];
            rhs_reg[a] <= rhs_next[a];
        end
        l2_reg <= MAG_W'(side_reg) * MAG_W'(side_reg);
    end

    // stage 1: d.n and (c - o).n terms
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_c[i]      = {center_reg[i][CRD_W-1], center_reg[i]}
                           - {in_o[i][CRD_W-1], in_o[i]};
            s1_pdn_next[i] = DN_W'(in_d[i]) * DN_W'(normal_reg[i]);
            s1_pcn_next[i] = CN_W'(diff_c[i]) * CN_W'(normal_reg[i]);
        end
    end

    // stage 2: sums
    always_comb
    begin
        s2_den_next = DEN_W'(s1_pdn_reg[0]) + DEN_W'(s1_pdn_reg[1]) + DEN_W'(s1_pdn_reg[2]);
        s2_num_next = NUM_W'(s1_pcn_reg[0]) + NUM_W'(s1_pcn_reg[1]) + NUM_W'(s1_pcn_reg[2]);
    end

    // stage 3 feeds the divider: magnitudes, sign and overflow checks
    always_comb
    begin
        num_neg = s2_num_reg[NUM_W-1];
        den_neg = s2_den_reg[DEN_W-1];
        an_c    = num_neg ? NUM_W'(-s2_num_reg) : NUM_W'(s2_num_reg);
        ad_c    = den_neg ? DEN_W'(-s2_den_reg) : DEN_W'(s2_den_reg);
        rem0_c  = RW'(an_c >> (QW - FRAC_BITS));

        dv_valid_next[0] = s2_valid_reg;
        // quotient of 2^32 or more is beyond any distance limit
        dv_miss_next[0]  = (s2_den_reg == '0) || (s2_num_reg == '0)
                         || (num_neg != den_neg) || (rem0_c >= RW'(ad_c));
        dv_rem_next[0]   = rem0_c;
        dv_nlo_next[0]   = {an_c[QW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        dv_q_next[0]     = '0;
        dv_dmag_next[0]  = ad_c;
        dv_lim_next[0]   = s2_lim_reg;
        dv_o_next[0]     = s2_o_reg;
        dv_d_next[0]     = s2_d_reg;

        // restoring division, one quotient bit per stage
        for (int k = 0; k < QW; k++)
        begin
            trial_c[k] = {dv_rem_reg[k][RW-2:0], dv_nlo_reg[k][QW-1]};
            ge_c[k]    = trial_c[k] >= RW'(dv_dmag_reg[k]);
            dv_rem_next[k+1]   = ge_c[k] ? trial_c[k] - RW'(dv_dmag_reg[k]) : trial_c[k];
            dv_q_next[k+1]     = {dv_q_reg[k][QW-2:0], ge_c[k]};
            dv_nlo_next[k+1]   = dv_nlo_reg[k] << 1;
            dv_valid_next[k+1] = dv_valid_reg[k];
            dv_miss_next[k+1]  = dv_miss_reg[k];
            dv_dmag_next[k+1]  = dv_dmag_reg[k];
            dv_lim_next[k+1]   = dv_lim_reg[k];
            dv_o_next[k+1]     = dv_o_reg[k];
            dv_d_next[k+1]     = dv_d_reg[k];
        end
    end

    // stage M: t range and d*t
    always_comb
    begin
        sm_miss_next = dv_miss_reg[QW]
                     || (dv_q_reg[QW] > QW'(dv_lim_reg[QW]))
                     || (dv_q_reg[QW] < T_MIN);
        for (int i = 0; i < 3; i++)
        begin
            sm_prod_next[i] = PRD_W'(dv_d_reg[QW][i])
                            * PRD_W'($signed({1'b0, dv_q_reg[QW][LEN_W-1:0]}));
        end
    end

    // stage V: v = o + floor(d*t / one) - c
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sv_wide_c[i] = PRD_W'(sm_o_reg[i]) + (sm_prod_reg[i] >>> FRAC_BITS)
                         - PRD_W'(center_reg[i]);
        end
    end

    // size test: dot products, magnitudes, squares, compare
    always_comb
    begin
        sd2_dot_next[0] = DW'(sd1_ps_reg[0]) + DW'(sd1_ps_reg[1]) + DW'(sd1_ps_reg[2]);
        sd2_dot_next[1] = DW'(sd1_pu_reg[0]) + DW'(sd1_pu_reg[1]) + DW'(sd1_pu_reg[2]);
        for (int a = 0; a < 2; a++)
        begin
            mag_c[a] = sd2_dot_reg[a][DW-1] ? DW'(-sd2_dot_reg[a]) : DW'(sd2_dot_reg[a]);
            sd4_pp_next[a][0] = MAG_W'(sd3_mag_reg[a][MAG_W-1:HALF_W])
                              * MAG_W'(sd3_mag_reg[a][MAG_W-1:HALF_W]);
            sd4_pp_next[a][1] = MAG_W'(sd3_mag_reg[a][MAG_W-1:HALF_W])
                              * MAG_W'(sd3_mag_reg[a][HALF_W-1:0]);
            sd4_pp_next[a][2] = MAG_W'(sd3_mag_reg[a][HALF_W-1:0])
                              * MAG_W'(sd3_mag_reg[a][HALF_W-1:0]);
            // 4 * dot^2 from the three partial products
            lhs_c[a] = ((CMP_W'(sd4_pp_reg[a][0]) << MAG_W)
                     + (CMP_W'(sd4_pp_reg[a][1]) << (HALF_W + 1))
                     + CMP_W'(sd4_pp_reg[a][2])) << 2;
            ok_c[a]  = !sd4_big_reg[a] && (lhs_c[a] <= rhs_reg[a]);
        end
        pv_hit_next = !sd4_miss_reg && !sdeg_reg && ok_c[0] && ok_c[1];
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            sm_valid_reg  <= 1'b0;
            sv_valid_reg  <= 1'b0;
            sd1_valid_reg <= 1'b0;
            sd2_valid_reg <= 1'b0;
            sd3_valid_reg <= 1'b0;
            sd4_valid_reg <= 1'b0;
            pv_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            for (int k = 0; k <= QW; k++)
            begin
                dv_valid_reg[k] <= dv_valid_next[k];
            end
            sm_valid_reg  <= dv_valid_reg[QW];
            sv_valid_reg  <= sm_valid_reg;
            sd1_valid_reg <= sv_valid_reg;
            sd2_valid_reg <= sd1_valid_reg;
            sd3_valid_reg <= sd2_valid_reg;
            sd4_valid_reg <= sd3_valid_reg;
            pv_valid_reg  <= sd4_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_o_reg    <= in_o;
            s1_d_reg    <= in_d;
            s1_lim_reg  <= max_distance;
            s1_pdn_reg  <= s1_pdn_next;
            s1_pcn_reg  <= s1_pcn_next;

            s2_o_reg    <= s1_o_reg;
            s2_d_reg    <= s1_d_reg;
            s2_lim_reg  <= s1_lim_reg;
            s2_den_reg  <= s2_den_next;
            s2_num_reg  <= s2_num_next;

            for (int k = 0; k <= QW; k++)
            begin
                dv_miss_reg[k] <= dv_miss_next[k];
                dv_rem_reg[k]  <= dv_rem_next[k];
                dv_nlo_reg[k]  <= dv_nlo_next[k];
                dv_q_reg[k]    <= dv_q_next[k];
                dv_dmag_reg[k] <= dv_dmag_next[k];
                dv_lim_reg[k]  <= dv_lim_next[k];
                dv_o_reg[k]    <= dv_o_next[k];
                dv_d_reg[k]    <= dv_d_next[k];
            end

            sm_miss_reg <= sm_miss_next;
            sm_t_reg    <= dv_q_reg[QW][LEN_W-1:0];
            sm_o_reg    <= dv_o_reg[QW];
            sm_prod_reg <= sm_prod_next;

            sv_miss_reg <= sm_miss_reg;
            sv_t_reg    <= sm_t_reg;
            for (int i = 0; i < 3; i++)
            begin
                sv_v_reg[i]   <= sv_wide_c[i][VW-1:0];
                sd1_ps_reg[i] <= PDW'(sv_v_reg[i]) * PDW'(s_reg[i]);
                sd1_pu_reg[i] <= PDW'(sv_v_reg[i]) * PDW'(u_reg[i]);
            end

            sd1_miss_reg <= sv_miss_reg;
            sd1_t_reg    <= sv_t_reg;

            sd2_miss_reg <= sd1_miss_reg;
            sd2_t_reg    <= sd1_t_reg;
            sd2_dot_reg  <= sd2_dot_next;

            sd3_miss_reg <= sd2_miss_reg;
            sd3_t_reg    <= sd2_t_reg;
            for (int a = 0; a < 2; a++)
            begin
                sd3_mag_reg[a] <= mag_c[a][MAG_W-1:0];
                sd3_big_reg[a] <= |mag_c[a][DW-1:MAG_W];
            end

            sd4_miss_reg <= sd3_miss_reg;
            sd4_t_reg    <= sd3_t_reg;
            sd4_big_reg  <= sd3_big_reg;
            sd4_pp_reg   <= sd4_pp_next;

            pv_hit_reg  <= pv_hit_next;
            pv_dist_reg <= pv_hit_next ? sd4_t_reg : '0;
        end
    end

    // output register with one-item skid
    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        skid_hit_next   = skid_hit_reg;
        skid_dist_next  = skid_dist_reg;
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        out_dist_next   = out_dist_reg;
        if (en)
        begin
            if (pv_valid_reg)
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = pv_hit_reg;
                    out_dist_next  = pv_dist_reg;
                end
                else
                begin
                    skid_valid_next = 1'b1;
                    skid_hit_next   = pv_hit_reg;
                    skid_dist_next  = pv_dist_reg;
                end
            end
            else if (out_free)
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_next  = 1'b1;
            out_hit_next    = skid_hit_reg;
            out_dist_next   = skid_dist_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skid_hit_reg  <= skid_hit_next;
        skid_dist_reg <= skid_dist_next;
        out_hit_reg   <= out_hit_next;
        out_dist_reg  <= out_dist_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign distance  = out_dist_reg;

endmodule

// File: hw/rtl/rsi_checker.sv
// Port-level checks for the ray/square intersection block, bound to the top level
`include "ray_square_intersect_macros.svh"

module rsi_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           hit,
    input logic [rsi_pkg::LEN_W-1:0]      distance
);
    import rsi_pkg::*;

    // a stalled result stays put
    `RSI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(hit) && $stable(distance))

    // a miss reports zero distance
    `RSI_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_valid && !hit, distance == '0)

    // a hit never lies nearer than the near limit
    `RSI_ASSERT_IMPL(a_hit_near, clk, rst_n, out_valid && hit, QW'(distance) >= T_MIN)

    // input stalls only after a held result backed up into the skid register
    `RSI_ASSERT_IMPL(a_stall_cause, clk, rst_n, $rose(in_stall), $past(out_valid && out_stall))

endmodule

bind ray_square_intersect rsi_checker u_rsi_checker (.*);
